// File: hw/rtl/sm4_block_cipher_macros.svh
// assertion macros for the sm4 block cipher checker
`ifndef SM4_BLOCK_CIPHER_MACROS_SVH
`define SM4_BLOCK_CIPHER_MACROS_SVH

`define SM4_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sm4 check failed");

`define SM4_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sm4 check failed");

`endif

// File: hw/rtl/sm4_pkg.sv
`default_nettype none
package sm4_pkg;

    localparam int ROUNDS_DEF = 32;
    localparam int WORD_W = 32;
    localparam int HALF_W = 64;
    localparam int BLOCK_W = 128;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW = 1'b1;

    localparam logic [WORD_W-1:0] FK0 = 32'hA3B1BAC6;
    localparam logic [WORD_W-1:0] FK1 = 32'h56AA3350;
    localparam logic [WORD_W-1:0] FK2 = 32'h677D9197;
    localparam logic [WORD_W-1:0] FK3 = 32'hB27022DC;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [WORD_W-1:0] tau(input logic [WORD_W-1:0] v);
        tau = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
        rotl = (v << n) | (v >> (WORD_W - n));
    endfunction

    // ck byte j of round i is (4*i + j) * 7 mod 256
    function automatic logic [WORD_W-1:0] ck_word(input logic [4:0] i);
        logic [7:0] b0;
        b0 = 8'({i, 2'b00}) * 8'd7;
        ck_word = {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
    endfunction

    // key schedule and data round share the cell, key_mode picks the linear map
    function automatic logic [WORD_W-1:0] round_f(input logic [WORD_W-1:0] x0,
                                                  input logic [WORD_W-1:0] mix,
                                                  input logic key_mode);
        logic [WORD_W-1:0] b;
        b = tau(mix);
        if (key_mode) begin
            round_f = x0 ^ b ^ rotl(b, 13) ^ rotl(b, 23);
        end else begin
            round_f = x0 ^ b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
        end
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sm4_block_cipher.sv
`default_nettype none
// SM4 block cipher core, 128-bit key and block. A request is accepted whenever the core is
// idle; a finished result waits in the output register, and the core holds its last step
// until that register is free. A block runs a load step, 32 rounds (one round per
// cycle in a row of four shifting word cells, round keys read from a 32-word RAM) and a
// step that moves the result out; a new request is accepted only when the core is idle
// again, so blocks do not overlap. The first block after reset or a key write first runs
// a key load step and the key schedule through the same cells. Key writes must be made
// only while the core is idle.
module sm4_block_cipher #(
    parameter int ROUNDS = sm4_pkg::ROUNDS_DEF
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cfg_we,
    input  wire  [0:0]   cfg_index,
    input  wire  [63:0]  cfg_wdata,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [127:0] s_tdata,   // block_high, block_low
    input  wire          s_tuser,   // command
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [127:0] m_tdata    // result_high, result_low
);
    import sm4_pkg::*;

    localparam int AW = $clog2(ROUNDS);

    typedef enum logic [2:0] {ST_IDLE, ST_KLOAD, ST_KEY, ST_DLOAD, ST_RUN, ST_DONE}
        state_t;

    state_t            state_reg;
    logic [63:0]       key_high_reg, key_low_reg;
    logic              keys_ready_reg;
    logic              dec_reg;
    logic [127:0]      blk_reg;
    logic [AW:0]       cnt_reg;
    logic              m_valid_reg;
    logic [127:0]      m_data_reg;

    logic              load;
    logic              shift;
    logic [WORD_W-1:0] load_w [4];
    logic [WORD_W-1:0] w [4];
    logic [WORD_W-1:0] nw;
    logic [WORD_W-1:0] rk;
    logic [AW-1:0]     rd_addr;
    logic              key_mode;

    assign key_mode = (state_reg == ST_KEY);
    assign load = (state_reg == ST_KLOAD) || (state_reg == ST_DLOAD);
    assign shift = key_mode || (state_reg == ST_RUN);

    always_comb begin
        if (state_reg == ST_KLOAD) begin
            load_w[0] = key_high_reg[63:32] ^ FK0;
            load_w[1] = key_high_reg[31:0] ^ FK1;
            load_w[2] = key_low_reg[63:32] ^ FK2;
            load_w[3] = key_low_reg[31:0] ^ FK3;
        end else begin
            load_w[0] = blk_reg[63:32];
            load_w[1] = blk_reg[31:0];
            load_w[2] = blk_reg[127:96];
            load_w[3] = blk_reg[95:64];
        end
    end

    // read address runs one ahead of the round for the registered ram
    always_comb begin
        if (state_reg == ST_RUN) begin
            rd_addr = cnt_reg[AW-1:0] + AW'(1);
        end else begin
            rd_addr = '0;
        end
        if (dec_reg) begin
            rd_addr = AW'(ROUNDS - 1) - rd_addr;
        end
    end

    assign nw = round_f(w[0], w[1] ^ w[2] ^ w[3] ^ (key_mode ? ck_word(5'(cnt_reg)) : rk),
                        key_mode);

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_cell
            sm4_cell u_cell (
                .aclk      (aclk),
                .load      (load),
                .load_word (load_w[g]),
                .shift     (shift),
                .shift_in  (g == 3 ? nw : w[(g + 1) % 4]),
                .word      (w[g])
            );
        end
    endgenerate

    sm4_ram #(.WIDTH(WORD_W), .DEPTH(ROUNDS)) u_rk_ram (
        .aclk    (aclk),
        .wr_en   (key_mode),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (nw),
        .rd_addr (rd_addr),
        .rd_data (rk)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            key_high_reg <= '0;
            key_low_reg <= '0;
            keys_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            m_data_reg <= '0;
            cnt_reg <= '0;
            dec_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                keys_ready_reg <= 1'b0;
                if (cfg_index == REG_KEY_HIGH) begin
                    key_high_reg <= cfg_wdata;
                end else begin
                    key_low_reg <= cfg_wdata;
                end
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        blk_reg <= s_tdata;
                        dec_reg <= (s_tuser == CMD_DECRYPT);
                        state_reg <= keys_ready_reg ? ST_DLOAD : ST_KLOAD;
                    end
                end
                ST_KLOAD: begin
                    cnt_reg <= '0;
                    state_reg <= ST_KEY;
                end
                ST_KEY: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (AW+1)'(ROUNDS - 1)) begin
                        keys_ready_reg <= 1'b1;
                        state_reg <= ST_DLOAD;
                    end
                end
                ST_DLOAD: begin
                    cnt_reg <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (AW+1)'(ROUNDS - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_data_reg <= {w[1], w[0], w[3], w[2]};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/sm4_ram.sv
`default_nettype none
module sm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire [WIDTH-1:0]          wr_data,
    input  wire [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/sm4_cell.sv
`default_nettype none
// one word cell of the shifting state row
module sm4_cell (
    input  wire                         aclk,
    input  wire                         load,
    input  wire  [sm4_pkg::WORD_W-1:0]  load_word,
    input  wire                         shift,
    input  wire  [sm4_pkg::WORD_W-1:0]  shift_in,
    output logic [sm4_pkg::WORD_W-1:0]  word
);
    import sm4_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb begin
        word_next = word_reg;
        if (load) begin
            word_next = load_word;
        end else if (shift) begin
            word_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;
endmodule
`default_nettype wire

// File: hw/rtl/sm4_block_cipher_checker.sv
`default_nettype none
`include "sm4_block_cipher_macros.svh"
module sm4_block_cipher_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [127:0] m_tdata
);
    `SM4_ASSERT_NEXT(a_out_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `SM4_ASSERT_IMPL(a_out_known, aclk, aresetn, m_tvalid, !$isunknown(m_tdata))
    `SM4_ASSERT_NEXT(a_request_not_instant, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `SM4_ASSERT_NEXT(a_data_quiet, aclk, aresetn, s_tvalid && s_tready, $stable(m_tdata))
endmodule

bind sm4_block_cipher sm4_block_cipher_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
